FILE: rtl/core/fde_pkg.sv
// Shared types and constants for the FAT directory entry parser.
// Used by every module in rtl/core; no dependencies.
package fde_pkg;

    localparam int unsigned ENTRY_BYTES = 32;
    localparam int unsigned POS_W       = $clog2(ENTRY_BYTES);
    localparam int unsigned COUNT_W     = 16;

    localparam logic [POS_W-1:0]   LAST_POS     = POS_W'(ENTRY_BYTES - 1);
    localparam logic [7:0]         MARK_END     = 8'h00;
    localparam logic [7:0]         MARK_DELETED = 8'hE5;
    localparam logic [7:0]         ATTR_VOLUME  = 8'h08;
    localparam logic [7:0]         ATTR_LOW     = 8'h0F;
    localparam logic [7:0]         ATTR_DIR     = 8'h10;
    localparam logic [7:0]         SPACE_CHAR   = 8'h20;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] MAX_RESET    = 16'd65535;

    localparam logic KIND_FILE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef logic [ENTRY_BYTES-1:0][7:0] entry_bytes_t;

    typedef struct packed {
        logic               fire;
        logic               is_end;
        logic [COUNT_W-1:0] count;
        logic               last;
    } entry_ctrl_t;

    typedef struct packed {
        logic               kind;
        logic [63:0]        name_chars;
        logic [3:0]         name_len;
        logic [23:0]        ext_chars;
        logic [1:0]         ext_len;
        logic [7:0]         attributes;
        logic               is_directory;
        logic [31:0]        start_cluster;
        logic [31:0]        file_size;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } result_t;

endpackage

FILE: rtl/core/fat_directory_entry_parser.sv
// Top level of the FAT short directory entry parser.
// Instantiates fde_collect, fde_format and fde_out; depends on fde_pkg.
//
// Usage:
//   Item channel (item_valid/item_stall) carries one directory byte per
//   transfer plus new_listing, which restarts position, count and done.
//   Every 32nd byte closes an entry; an accepted file entry or the
//   end-of-directory marker produces one result on the result channel
//   (result_valid/result_stall). Deleted, volume, and entries with any
//   low attribute bit give no result.
//   Throughput: one byte per cycle while item_stall is low. The result
//   appears the cycle after the transfer of the entry's final byte.
//   item_stall rises only when a result is held by a stalled receiver and
//   the next byte would close an entry; all other bytes keep flowing.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes max_entries;
//   cfg_ready is always high.
//   Reset clears position, count, done and the result valid flag;
//   max_entries resets to 65535.
module fat_directory_entry_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        new_listing,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [63:0] name_chars,
    output logic [3:0]  name_len,
    output logic [23:0] ext_chars,
    output logic [1:0]  ext_len,
    output logic [7:0]  attributes,
    output logic        is_directory,
    output logic [31:0] start_cluster,
    output logic [31:0] file_size,
    output logic [15:0] entry_count,
    output logic        last
);
    import fde_pkg::*;

    logic [COUNT_W-1:0] max_reg;
    logic               take, hold, at_last_pos;
    entry_bytes_t       entry_bytes;
    entry_ctrl_t        ctrl;
    result_t            res_comb, res_q;

    assign cfg_ready  = 1'b1;
    assign item_stall = hold && at_last_pos;
    assign take       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_reg <= cfg_data;
        end
    end

    fde_collect u_collect (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (data_byte),
        .new_listing (new_listing),
        .max_entries (max_reg),
        .at_last_pos (at_last_pos),
        .entry_bytes (entry_bytes),
        .ctrl        (ctrl)
    );

    fde_format u_format (
        .entry_bytes (entry_bytes),
        .ctrl        (ctrl),
        .result      (res_comb)
    );

    fde_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (ctrl.fire),
        .result_in    (res_comb),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .hold         (hold),
        .result_out   (res_q)
    );

    assign kind          = res_q.kind;
    assign name_chars    = res_q.name_chars;
    assign name_len      = res_q.name_len;
    assign ext_chars     = res_q.ext_chars;
    assign ext_len       = res_q.ext_len;
    assign attributes    = res_q.attributes;
    assign is_directory  = res_q.is_directory;
    assign start_cluster = res_q.start_cluster;
    assign file_size     = res_q.file_size;
    assign entry_count   = res_q.entry_count;
    assign last          = res_q.last;

`ifndef SYNTHESIS
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_END |-> last)
        else $error("end marker result without last");

    a_end_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_END |-> name_len == 4'd0 && file_size == 32'd0)
        else $error("end marker result with nonzero entry fields");

    a_file_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_FILE |-> entry_count != 16'd0)
        else $error("file result with zero count");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result");
`endif

endmodule

FILE: rtl/core/fde_collect.sv
// Byte collector: entry buffer, byte position, accepted count and done flag.
// Judges each entry on its final byte. Depends on fde_pkg.
module fde_collect (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [7:0]                  data_byte,
    input  logic                        new_listing,
    input  logic [fde_pkg::COUNT_W-1:0] max_entries,
    output logic                        at_last_pos,
    output fde_pkg::entry_bytes_t       entry_bytes,
    output fde_pkg::entry_ctrl_t        ctrl
);
    import fde_pkg::*;

    logic [7:0]         buf_reg [0:ENTRY_BYTES-2];
    logic [POS_W-1:0]   pos_reg, pos_next, pos_eff;
    logic [COUNT_W-1:0] cnt_reg, cnt_next, cnt_eff, cnt_inc, limit;
    logic               done_reg, done_next, done_eff;
    logic               last_byte, is_end, skip, stop;
    logic [7:0]         attr;

    always_comb
    begin
        pos_eff  = new_listing ? '0 : pos_reg;
        cnt_eff  = new_listing ? '0 : cnt_reg;
        done_eff = new_listing ? 1'b0 : done_reg;

        for (int i = 0; i < ENTRY_BYTES - 1; i++)
        begin
            entry_bytes[i] = buf_reg[i];
        end
        entry_bytes[ENTRY_BYTES-1] = data_byte;

        last_byte = (pos_eff == LAST_POS);
        attr      = buf_reg[11];
        is_end    = (buf_reg[0] == MARK_END);
        skip      = (buf_reg[0] == MARK_DELETED) || ((attr & (ATTR_VOLUME | ATTR_LOW)) != 8'h00);
        cnt_inc   = (cnt_eff != COUNT_MAX) ? cnt_eff + COUNT_W'(1) : cnt_eff;
        limit     = (max_entries == '0) ? COUNT_W'(1) : max_entries;
        stop      = (cnt_inc >= limit);

        ctrl.fire   = take && !done_eff && last_byte && (is_end || !skip);
        ctrl.is_end = is_end;
        ctrl.count  = is_end ? cnt_eff : cnt_inc;
        ctrl.last   = is_end || stop;

        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (take)
        begin
            pos_next  = pos_eff;
            cnt_next  = cnt_eff;
            done_next = done_eff;
            if (!done_eff)
            begin
                if (!last_byte)
                begin
                    pos_next = pos_eff + POS_W'(1);
                end
                else
                begin
                    pos_next = '0;
                    if (is_end)
                    begin
                        done_next = 1'b1;
                    end
                    else if (!skip)
                    begin
                        cnt_next  = cnt_inc;
                        done_next = stop;
                    end
                end
            end
        end
    end

    assign at_last_pos = (pos_reg == LAST_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !done_eff && !last_byte)
        begin
            buf_reg[pos_eff] <= data_byte;
        end
    end

endmodule

FILE: rtl/core/fde_format.sv
// Result assembly: 8.3 name and extension lengths, cluster and size fields.
// Purely combinational. Depends on fde_pkg.
module fde_format (
    input  fde_pkg::entry_bytes_t entry_bytes,
    input  fde_pkg::entry_ctrl_t  ctrl,
    output fde_pkg::result_t      result
);
    import fde_pkg::*;

    logic [3:0] nlen;
    logic [1:0] elen;
    logic       nhit, ehit;

    always_comb
    begin
        nlen = '0;
        nhit = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (entry_bytes[i] == SPACE_CHAR)
            begin
                nhit = 1'b1;
            end
            else if (!nhit)
            begin
                nlen = nlen + 4'd1;
            end
        end
        elen = '0;
        ehit = 1'b0;
        for (int i = 8; i < 11; i++)
        begin
            if (entry_bytes[i] == SPACE_CHAR)
            begin
                ehit = 1'b1;
            end
            else if (!ehit)
            begin
                elen = elen + 2'd1;
            end
        end

        result             = '0;
        result.entry_count = ctrl.count;
        result.last        = ctrl.last;
        if (ctrl.is_end)
        begin
            result.kind = KIND_END;
        end
        else
        begin
            result.kind          = KIND_FILE;
            result.name_chars    = {entry_bytes[7], entry_bytes[6], entry_bytes[5],
                                    entry_bytes[4], entry_bytes[3], entry_bytes[2],
                                    entry_bytes[1], entry_bytes[0]};
            result.name_len      = nlen;
            result.ext_chars     = {entry_bytes[10], entry_bytes[9], entry_bytes[8]};
            result.ext_len       = elen;
            result.attributes    = entry_bytes[11];
            result.is_directory  = (entry_bytes[11] & ATTR_DIR) != 8'h00;
            result.start_cluster = {entry_bytes[21], entry_bytes[20],
                                    entry_bytes[27], entry_bytes[26]};
            result.file_size     = {entry_bytes[31], entry_bytes[30],
                                    entry_bytes[29], entry_bytes[28]};
        end
    end

endmodule

FILE: rtl/core/fde_out.sv
// Result register with valid/stall handshake toward the receiver.
// Depends on fde_pkg.
module fde_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fde_pkg::result_t result_in,
    input  logic             result_stall,
    output logic             result_valid,
    output logic             hold,
    output fde_pkg::result_t result_out
);
    import fde_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result_in;
        end
    end

    assign result_valid = valid_reg;
    assign hold         = valid_reg && result_stall;
    assign result_out   = res_reg;

endmodule

FILE: test/fat_directory_entry_parser_tb.sv
// Self-checking testbench for fat_directory_entry_parser: directory bytes go in one per
// transfer, results are checked field by field against table rows or an in-bench model.
// Depends on rtl/core/fde_pkg.sv and rtl/core/fat_directory_entry_parser.sv.
module fat_directory_entry_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fde_pkg::*;

    typedef struct packed {
        bit          restart;
        bit          typed;
        logic [63:0] name;
        logic [23:0] ext;
        logic [7:0]  attr;
        logic [31:0] cluster;
        logic [31:0] size;
        result_t     want;
    } dir_row_t;

    localparam result_t     NO_RESULT      = '0;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned TARGET_BYTES   = 1650;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [7:0]  data_byte;
    logic        new_listing;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic        result_stall;
    logic        kind;
    logic [63:0] name_chars;
    logic [3:0]  name_len;
    logic [23:0] ext_chars;
    logic [1:0]  ext_len;
    logic [7:0]  attributes;
    logic        is_directory;
    logic [31:0] start_cluster;
    logic [31:0] file_size;
    logic [15:0] entry_count;
    logic        last;

    // parser model state
    entry_bytes_t         cur_entry;
    logic [POS_W-1:0]     byte_pos       = '0;
    logic [COUNT_W-1:0]   files_accepted = '0;
    bit                   listing_done   = 1'b0;
    logic [15:0]          max_cfg        = MAX_RESET;

    result_t     pending_entries [$];
    int unsigned bytes_taken  = 0;
    int unsigned mismatches   = 0;
    bit          zero_gaps    = 1'b0;
    bit          hold_req     = 1'b0;

    fat_directory_entry_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .data_byte     (data_byte),
        .new_listing   (new_listing),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .name_chars    (name_chars),
        .name_len      (name_len),
        .ext_chars     (ext_chars),
        .ext_len       (ext_len),
        .attributes    (attributes),
        .is_directory  (is_directory),
        .start_cluster (start_cluster),
        .file_size     (file_size),
        .entry_count   (entry_count),
        .last          (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit parse_byte(input logic [7:0] b, input bit restart,
                                       output result_t res, output bit taken);
        logic [7:0]         attr;
        logic [COUNT_W-1:0] limit;
        res   = NO_RESULT;
        taken = 1'b0;
        if (restart)
        begin
            byte_pos       = '0;
            files_accepted = '0;
            listing_done   = 1'b0;
        end
        if (listing_done)
            return 1'b0;
        taken = 1'b1;
        cur_entry[byte_pos] = b;
        if (byte_pos != LAST_POS)
        begin
            byte_pos++;
            return 1'b0;
        end
        byte_pos = '0;

        if (cur_entry[0] == MARK_END)
        begin
            listing_done    = 1'b1;
            res.kind        = KIND_END;
            res.entry_count = files_accepted;
            res.last        = 1'b1;
            return 1'b1;
        end

        attr = cur_entry[11];
        if (cur_entry[0] == MARK_DELETED || (attr & ATTR_VOLUME) != 8'h00 ||
            (attr & ATTR_LOW) != 8'h00)
            return 1'b0;

        res.kind = KIND_FILE;
        res.name_len = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            res.name_chars[8*i +: 8] = cur_entry[i];
            if (cur_entry[i] == SPACE_CHAR)
                res.name_len = 4'(i);
        end
        res.ext_len = 2'd3;
        for (int i = 2; i >= 0; i--)
        begin
            res.ext_chars[8*i +: 8] = cur_entry[8+i];
            if (cur_entry[8+i] == SPACE_CHAR)
                res.ext_len = 2'(i);
        end
        res.attributes    = attr;
        res.is_directory  = (attr & ATTR_DIR) != 8'h00;
        res.start_cluster = {cur_entry[21], cur_entry[20], cur_entry[27], cur_entry[26]};
        res.file_size     = {cur_entry[31], cur_entry[30], cur_entry[29], cur_entry[28]};

        if (files_accepted != COUNT_MAX)
            files_accepted++;
        limit = (max_cfg == '0) ? COUNT_W'(1) : max_cfg;
        res.entry_count = files_accepted;
        if (files_accepted >= limit)
        begin
            listing_done = 1'b1;
            res.last     = 1'b1;
        end
        return 1'b1;
    endfunction

    // mostly well-formed files; deleted, end markers and raw bytes mixed in
    function automatic entry_bytes_t random_entry();
        entry_bytes_t e;
        int unsigned  pick, nlen, elen;
        for (int i = 0; i < ENTRY_BYTES; i++)
            e[i] = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            nlen = $urandom_range(0, 8);
            elen = $urandom_range(0, 3);
            for (int i = 0; i < 8; i++)
                e[i] = (i < nlen) ? 8'($urandom_range(33, 126)) : SPACE_CHAR;
            for (int i = 0; i < 3; i++)
                e[8+i] = (i < elen) ? 8'($urandom_range(33, 126)) : SPACE_CHAR;
            e[11] = {4'($urandom), 4'h0};
            if (pick < 15)
                e[$urandom_range(0, 10)] = SPACE_CHAR;
        end
        else if (pick < 70)
            e[0] = MARK_DELETED;
        else if (pick < 78)
            e[0] = MARK_END;
        return e;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %0h want %0h", what, got, want));
    endtask

    task automatic check_result();
        result_t want;
        if (pending_entries.size() == 0)
            report("result with no entry pending");
        else
        begin
            want = pending_entries.pop_front();
            check_field("kind", kind, want.kind);
            check_field("name_chars", name_chars, want.name_chars);
            check_field("name_len", name_len, want.name_len);
            check_field("ext_chars", ext_chars, want.ext_chars);
            check_field("ext_len", ext_len, want.ext_len);
            check_field("attributes", attributes, want.attributes);
            check_field("is_directory", is_directory, want.is_directory);
            check_field("start_cluster", start_cluster, want.start_cluster);
            check_field("file_size", file_size, want.file_size);
            check_field("entry_count", entry_count, want.entry_count);
            check_field("last", last, want.last);
        end
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic put_byte(input logic [7:0] b, input bit restart, input bit typed,
                            input result_t want);
        int unsigned gap;
        result_t     got;
        bit          taken;
        gap = zero_gaps ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid  = 1'b1;
        data_byte   = b;
        new_listing = restart;
        do @(posedge clk); while (item_stall);
        if (parse_byte(b, restart, got, taken))
            pending_entries.push_back(typed ? want : got);
        if (taken)
            bytes_taken++;
        @(negedge clk);
    endtask

    task automatic feed_entry(input entry_bytes_t e, input bit restart, input bit typed,
                              input result_t want);
        for (int i = 0; i < ENTRY_BYTES; i++)
            put_byte(e[i], restart && i == 0, typed, want);
    endtask

    task automatic settle();
        item_valid = 1'b0;
        while (pending_entries.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_max(input logic [15:0] value);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        max_cfg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int unsigned w;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            w = zero_gaps ? 0 : $urandom_range(0, 16);
            if (w != 0)
            begin
                result_stall = 1'b1;
                repeat (w) @(negedge clk);
            end
            result_stall = 1'b0;
            do @(posedge clk); while (!result_valid && !hold_req);
            if (result_valid)
                check_result();
            @(negedge clk);
        end
    end

    initial
    begin
        dir_row_t     rows [14];
        entry_bytes_t e;
        int unsigned  phase, n;
        logic [15:0]  next_max;
        bit           restart;

        rows = '{
            '{1'b1, 1'b1, "README  ", "TXT", 8'h20, 32'h0001_0002, 32'h0000_1234,
              '{KIND_FILE, 64'h2020_454D_4441_4552, 4'd6, 24'h54_5854, 2'd3, 8'h20, 1'b0,
                32'h0001_0002, 32'h0000_1234, 16'd1, 1'b0}},
            '{1'b0, 1'b1, "SUBDIR  ", "   ", 8'h10, 32'h0000_0003, 32'h0000_0000,
              '{KIND_FILE, 64'h2020_5249_4442_5553, 4'd6, 24'h20_2020, 2'd0, 8'h10, 1'b1,
                32'h0000_0003, 32'h0000_0000, 16'd2, 1'b0}},
            '{1'b0, 1'b0, 64'hE54F_4C44_2020_2020, "TXT", 8'h20, 32'h5, 32'h6, NO_RESULT},
            '{1'b0, 1'b0, "VOLUME  ", "   ", 8'h08, 32'h0, 32'h0, NO_RESULT},
            '{1'b0, 1'b0, 64'h4162_0063_0064_0065, 24'h006600, 8'h0F, 32'h0, 32'h0, NO_RESULT},
            '{1'b0, 1'b0, "RDONLY  ", "DAT", 8'h21, 32'h7, 32'h8, NO_RESULT},
            '{1'b0, 1'b0, "HIDDEN  ", "SYS", 8'h22, 32'h9, 32'hA, NO_RESULT},
            '{1'b0, 1'b0, "SYSTEM  ", "SYS", 8'h24, 32'hB, 32'hC, NO_RESULT},
            '{1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF, 8'hF0, 32'hFFFF_FFFF,
              32'hFFFF_FFFF,
              '{KIND_FILE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 24'hFF_FFFF, 2'd3, 8'hF0, 1'b1,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd3, 1'b0}},
            '{1'b0, 1'b0, "        ", "A A", 8'h00, 32'h1234_5678, 32'h9ABC_DEF0, NO_RESULT},
            '{1'b0, 1'b0, 64'h0100_0000_0000_0000, 24'h0, 8'h00, 32'h0, 32'h0, NO_RESULT},
            '{1'b0, 1'b1, 64'h0041_4243_4445_4647, "TXT", 8'h20, 32'h1, 32'h2,
              '{KIND_END, 64'h0, 4'd0, 24'h0, 2'd0, 8'h00, 1'b0, 32'h0, 32'h0, 16'd5, 1'b1}},
            '{1'b0, 1'b0, "LATE    ", "TXT", 8'h20, 32'h3, 32'h4, NO_RESULT},
            '{1'b1, 1'b0, "A       ", "B  ", 8'h30, 32'h0002_0001, 32'h100, NO_RESULT}
        };

        rst_n       = 1'b0;
        item_valid  = 1'b0;
        data_byte   = 8'h00;
        new_listing = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 16'h0000;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[r])
        begin
            for (int i = 0; i < ENTRY_BYTES; i++)
                e[i] = 8'($urandom);
            for (int i = 0; i < 8; i++)
                e[i] = rows[r].name[8*(7-i) +: 8];
            for (int i = 0; i < 3; i++)
                e[8+i] = rows[r].ext[8*(2-i) +: 8];
            e[11] = rows[r].attr;
            {e[21], e[20], e[27], e[26]} = rows[r].cluster;
            {e[31], e[30], e[29], e[28]} = rows[r].size;
            feed_entry(e, rows[r].restart, rows[r].typed, rows[r].want);
        end

        for (phase = 0; bytes_taken < TARGET_BYTES; phase++)
        begin
            settle();
            case (phase % 6)
                0:       next_max = 16'd1;
                1:       next_max = MAX_RESET;
                2:       next_max = 16'd0;
                3:       next_max = 16'($urandom_range(2, 5));
                4:       next_max = 16'($urandom);
                default: next_max = 16'($urandom_range(1, 12));
            endcase
            write_max(next_max);
            zero_gaps = (phase == 1) || (phase % 5 == 4);
            if (phase == 1)
                hold_req = 1'b1;
            n = (phase == 1) ? 10 : $urandom_range(1, 10);
            for (int k = 0; k < n && (k == 0 || !listing_done); k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 31))
                        put_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, NO_RESULT);
                restart = (k == 0) && ($urandom_range(0, 4) != 0);
                feed_entry(random_entry(), restart, 1'b0, NO_RESULT);
            end
            if (listing_done)
                repeat ($urandom_range(0, 8))
                    put_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
        end

        settle();
        if (mismatches == 0 && pending_entries.size() == 0)
            $display("PASS fat_directory_entry_parser");
        else
            $display("FAIL fat_directory_entry_parser");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL fat_directory_entry_parser");
        $finish;
    end

endmodule
